/* rtl/afc_pkg.sv */
`default_nettype none
package afc_pkg;

  localparam int unsigned CHUNK_X_SIZE = 16;
  localparam int unsigned CHUNK_Y_SIZE = 16;
  localparam int unsigned CHUNK_Z_SIZE = 16;

  localparam int unsigned CoordW  = 21;
  localparam int unsigned TagW    = 16;
  localparam int unsigned DistW   = 21;
  localparam int unsigned RegW    = 63;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned IdxW    = 3;

  // Box coordinates widened so that min + size never overflows.
  localparam int unsigned BoxW = 24;
  // Dot term: 21-bit normal times 24-bit coordinate.
  localparam int unsigned ProdW = 45;
  localparam int unsigned DotW  = 48;
  // Squared centre distance.
  localparam int unsigned SqW = 48;
  // Square root result width and number of root stages.
  localparam int unsigned RootW   = 24;
  localparam int unsigned RootStg = 6;
  localparam int unsigned BitsPerStg = RootW / RootStg;

  localparam logic signed [BoxW-1:0] HiOffX = BoxW'(CHUNK_X_SIZE * 16);
  localparam logic signed [BoxW-1:0] HiOffY = BoxW'(CHUNK_Y_SIZE * 16);
  localparam logic signed [BoxW-1:0] HiOffZ = BoxW'(CHUNK_Z_SIZE * 16);
  localparam logic signed [BoxW-1:0] CtrOffX = BoxW'(CHUNK_X_SIZE * 8);
  localparam logic signed [BoxW-1:0] CtrOffY = BoxW'(CHUNK_Y_SIZE * 8);
  localparam logic signed [BoxW-1:0] CtrOffZ = BoxW'(CHUNK_Z_SIZE * 8);

  localparam logic [DistW-1:0] DistMax = '1;

  typedef enum logic [IdxW-1:0] {
    REG_NORMAL_TOP    = 3'd0,
    REG_NORMAL_BOTTOM = 3'd1,
    REG_NORMAL_LEFT   = 3'd2,
    REG_NORMAL_RIGHT  = 3'd3,
    REG_LOOK          = 3'd4,
    REG_BOX_MIN       = 3'd5,
    REG_BOX_MAX       = 3'd6,
    REG_LIMITS        = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    VERDICT_SKIPPED = 3'd0,
    VERDICT_TOO_FAR = 3'd1,
    VERDICT_CULLED  = 3'd2,
    VERDICT_MESH    = 3'd3,
    VERDICT_VISIBLE = 3'd4
  } verdict_e;

  typedef struct packed {
    logic [TagW-1:0]     tag;
    logic [CoordW-1:0]   rel_x;
    logic [CoordW-1:0]   rel_y;
    logic [CoordW-1:0]   rel_z;
    logic                initialized;
    logic                mesh_ready;
  } in_beat_t;

  typedef struct packed {
    logic [TagW-1:0]  tag_out;
    logic [2:0]       verdict;
    logic [DistW-1:0] distance;
  } out_beat_t;

  // One product term of a minimum-corner dot product: the normal picks the
  // low corner when it is non-negative, else the high one.
  function automatic logic signed [ProdW-1:0] dot_term(
    input logic signed [CoordW-1:0] n,
    input logic signed [BoxW-1:0]   lo,
    input logic signed [BoxW-1:0]   hi
  );
    logic signed [BoxW-1:0] sel;
    sel = n[CoordW-1] ? hi : lo;
    return ProdW'(n * sel);
  endfunction

endpackage
`default_nettype wire

/* rtl/afc_stream_if.sv */
`default_nettype none
interface afc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/aabb_frustum_cull.sv */
`default_nettype none
// Channel   Dir  Width  Content
// in_if     in   81     tag, rel_x, rel_y, rel_z, initialized, mesh_ready
// out_if    out  40     tag_out, verdict, distance
// cfg       in   3+63   write enable, register index, register data
//
// One beat is accepted every cycle while the output stage is not stalled. The
// depth is set by the 24-bit square root, which is spread over six stages of
// four result bits each.
// Reset clears all valid bits and all configuration registers to zero.
// A stall freezes the whole pipeline; ready is high whenever the output
// stage is empty or being drained, so no beat is lost or repeated.
module aabb_frustum_cull (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  afc_stream_if.sink                    in_if,
  afc_stream_if.source                  out_if,
  input  wire                           cfg_we_i,
  input  wire [afc_pkg::IdxW-1:0]       cfg_idx_i,
  input  wire [afc_pkg::RegW-1:0]       cfg_data_i
);

  localparam int unsigned Stages = 3 + afc_pkg::RootStg;
  localparam int unsigned SW = afc_pkg::SqW;
  localparam int unsigned RW = afc_pkg::RootW;
  localparam int unsigned BW = afc_pkg::BitsPerStg;

  // Configuration registers.
  logic [afc_pkg::RegW-1:0] cfg_q [afc_pkg::NumRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < afc_pkg::NumRegs; i++) cfg_q[i] <= '0;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  function automatic logic signed [afc_pkg::CoordW-1:0] comp(
    input logic [afc_pkg::RegW-1:0] r, input int unsigned k);
    return r[k*afc_pkg::CoordW +: afc_pkg::CoordW];
  endfunction

  // Pipeline valid bits and the global advance.
  logic [Stages-1:0] vld_q;
  logic adv;
  assign adv = !vld_q[Stages-1] || out_if.ready;
  assign in_if.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Stages-2:0], in_if.valid};
    end
  end

  // Stage 1: box corners, centre and overlap test.
  afc_pkg::in_beat_t inb;
  assign inb = in_if.payload;
  logic signed [afc_pkg::BoxW-1:0] lo_d [3], hi_d [3], c_d [3];
  logic signed [afc_pkg::BoxW-1:0] lo1_q [3], hi1_q [3], c1_q [3];
  logic ovl_d, ovl1_q;
  logic [afc_pkg::TagW-1:0] tag_q [Stages];
  logic init_q [Stages];
  logic mr_q [Stages];

  always_comb begin
    logic signed [afc_pkg::BoxW-1:0] fmin, fmax, mx, mn;
    lo_d[0] = afc_pkg::BoxW'($signed(inb.rel_x));
    lo_d[1] = afc_pkg::BoxW'($signed(inb.rel_y));
    lo_d[2] = afc_pkg::BoxW'($signed(inb.rel_z));
    hi_d[0] = lo_d[0] + afc_pkg::HiOffX;
    hi_d[1] = lo_d[1] + afc_pkg::HiOffY;
    hi_d[2] = lo_d[2] + afc_pkg::HiOffZ;
    c_d[0]  = lo_d[0] + afc_pkg::CtrOffX;
    c_d[1]  = lo_d[1] + afc_pkg::CtrOffY;
    c_d[2]  = lo_d[2] + afc_pkg::CtrOffZ;
    ovl_d = 1'b1;
    for (int i = 0; i < 3; i++) begin
      fmin = afc_pkg::BoxW'(comp(cfg_q[afc_pkg::REG_BOX_MIN], i));
      fmax = afc_pkg::BoxW'(comp(cfg_q[afc_pkg::REG_BOX_MAX], i));
      mx = (lo_d[i] > fmin) ? lo_d[i] : fmin;
      mn = (hi_d[i] < fmax) ? hi_d[i] : fmax;
      if (mx > mn) ovl_d = 1'b0;
    end
  end

  // Stage 2: products (per plane, per axis) and centre squares.
  logic signed [afc_pkg::ProdW-1:0] prod2_q [5][3];
  logic [SW-1:0] sq2_q [3];
  logic ovl2_q;

  // Stage 3: plane sums and squared distance.
  logic out3_q;
  logic [SW-1:0] sum3_q;

  // Root stages.
  logic [SW-1:0] rem_q [afc_pkg::RootStg];
  logic [RW-1:0] root_q [afc_pkg::RootStg];
  logic cull_q [afc_pkg::RootStg];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lo1_q <= lo_d; hi1_q <= hi_d; c1_q <= c_d; ovl1_q <= ovl_d;
      tag_q[0] <= inb.tag; init_q[0] <= inb.initialized; mr_q[0] <= inb.mesh_ready;
      for (int s = 1; s < Stages; s++) begin
        tag_q[s] <= tag_q[s-1]; init_q[s] <= init_q[s-1]; mr_q[s] <= mr_q[s-1];
      end
      for (int p = 0; p < 5; p++)
        for (int i = 0; i < 3; i++)
          prod2_q[p][i] <= afc_pkg::dot_term(comp(cfg_q[p], i), lo1_q[i], hi1_q[i]);
      for (int i = 0; i < 3; i++)
        sq2_q[i] <= SW'(c1_q[i] * c1_q[i]);
      ovl2_q <= ovl1_q;
    end
  end

  // Plane decision in stage 3.
  logic out3_d;
  always_comb begin
    logic signed [afc_pkg::DotW-1:0] s;
    logic signed [afc_pkg::DotW-1:0] far;
    far = afc_pkg::DotW'($signed(cfg_q[afc_pkg::REG_LIMITS][62:32]));
    out3_d = !ovl2_q;
    for (int p = 0; p < 5; p++) begin
      s = afc_pkg::DotW'(prod2_q[p][0]) + afc_pkg::DotW'(prod2_q[p][1])
        + afc_pkg::DotW'(prod2_q[p][2]);
      if (p == afc_pkg::REG_LOOK) s = s - far;
      if (!s[afc_pkg::DotW-1]) out3_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out3_q <= out3_d;
      sum3_q <= sq2_q[0] + sq2_q[1] + sq2_q[2];
    end
  end

  // Bitwise square root: four result bits per stage, most significant first.
  logic [SW-1:0] rem_d [afc_pkg::RootStg];
  logic [RW-1:0] root_d [afc_pkg::RootStg];
  always_comb begin
    logic [SW-1:0] r;
    logic [RW-1:0] q;
    logic [SW+1:0] trial;
    for (int s = 0; s < afc_pkg::RootStg; s++) begin
      r = (s == 0) ? sum3_q : rem_q[s-1];
      q = (s == 0) ? '0 : root_q[s-1];
      for (int b = 0; b < BW; b++) begin
        trial = ((SW+2)'(q) << (RW - s*BW - b)) | ((SW+2)'(1) << (2*(RW-1-s*BW-b)));
        if ((SW+2)'(r) >= trial) begin
          r = SW'((SW+2)'(r) - trial);
          q = q | (RW'(1) << (RW-1-s*BW-b));
        end
      end
      rem_d[s] = r;
      root_d[s] = q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < afc_pkg::RootStg; s++) begin
        rem_q[s] <= rem_d[s];
        root_q[s] <= root_d[s];
        cull_q[s] <= (s == 0) ? out3_q : cull_q[s-1];
      end
    end
  end

  // Output: verdict and saturated distance.
  afc_pkg::out_beat_t ob;
  always_comb begin
    logic [RW-1:0] d;
    logic [31:0] lim;
    d = root_q[afc_pkg::RootStg-1];
    lim = cfg_q[afc_pkg::REG_LIMITS][31:0];
    ob.tag_out = tag_q[Stages-1];
    ob.distance = (d > RW'(afc_pkg::DistMax)) ? afc_pkg::DistMax : d[afc_pkg::DistW-1:0];
    if (!init_q[Stages-1])                 ob.verdict = afc_pkg::VERDICT_SKIPPED;
    else if (32'(d) > lim)                 ob.verdict = afc_pkg::VERDICT_TOO_FAR;
    else if (cull_q[afc_pkg::RootStg-1])   ob.verdict = afc_pkg::VERDICT_CULLED;
    else if (!mr_q[Stages-1])              ob.verdict = afc_pkg::VERDICT_MESH;
    else                                   ob.verdict = afc_pkg::VERDICT_VISIBLE;
  end

  assign out_if.valid = vld_q[Stages-1];
  assign out_if.payload = ob;

endmodule
`default_nettype wire

/* rtl/afc_checker.sv */
`default_nettype none
module afc_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire [39:0] out_payload
);
  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result beat changed while stalled");

  // Input is taken whenever the output side drains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // Verdict code stays in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_payload[23:21] <= 3'd4)
    else $error("verdict out of range");

  // Input ready only drops while a result is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without backpressure");
endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_payload(out_if.payload)
);
`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PipeDepth = 9;
  localparam int RandItems = 1430;
  localparam int ItemsPerSet = 286;

  typedef longint vec3_t [3];

  typedef struct {
    int                cfg_set;
    logic [15:0]       tag;
    int                x;
    int                y;
    int                z;
    bit                init;
    bit                ready;
    bit                typed;
    afc_pkg::verdict_e verdict;
    int                exp_dist;
  } cull_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we;
  logic [afc_pkg::IdxW-1:0] cfg_idx;
  logic [afc_pkg::RegW-1:0] cfg_data;

  afc_stream_if #(.payload_t(afc_pkg::in_beat_t))  in_if ();
  afc_stream_if #(.payload_t(afc_pkg::out_beat_t)) out_if ();

  aabb_frustum_cull uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Shadow copy of the frustum registers and the results still to come.
  logic [afc_pkg::RegW-1:0] frustum_regs [afc_pkg::NumRegs];
  afc_pkg::out_beat_t       pending_culls [$];
  int              errors = 0;
  int              snd_idle = 0;
  int              rcv_idle = 0;
  int              cur_set = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("aabb_frustum_cull test failed");
    $finish;
  end

  function automatic logic [afc_pkg::RegW-1:0] pack3(int x, int y, int z);
    logic [20:0] px, py, pz;
    px = x[20:0];
    py = y[20:0];
    pz = z[20:0];
    return {pz, py, px};
  endfunction

  function automatic void unpack3(input logic [afc_pkg::RegW-1:0] r, output vec3_t v);
    v[0] = longint'($signed(r[20:0]));
    v[1] = longint'($signed(r[41:21]));
    v[2] = longint'($signed(r[62:42]));
  endfunction

  // Smallest dot product over the eight box corners.
  function automatic longint corner_min_dot(vec3_t lo, vec3_t hi, vec3_t n);
    longint s;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      s += n[i] * ((n[i] >= 0) ? lo[i] : hi[i]);
    end
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic afc_pkg::out_beat_t predict_cull(afc_pkg::in_beat_t b);
    vec3_t lo, hi, fmin, fmax, look, n;
    longint c, far_off, mx, mn;
    longint unsigned sq, root_dist, limit;
    bit overlap, culled;
    afc_pkg::out_beat_t r;
    lo[0] = longint'($signed(b.rel_x));
    lo[1] = longint'($signed(b.rel_y));
    lo[2] = longint'($signed(b.rel_z));
    hi[0] = lo[0] + afc_pkg::CHUNK_X_SIZE * 16;
    hi[1] = lo[1] + afc_pkg::CHUNK_Y_SIZE * 16;
    hi[2] = lo[2] + afc_pkg::CHUNK_Z_SIZE * 16;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      c = lo[i] + (i == 0 ? afc_pkg::CHUNK_X_SIZE :
                   i == 1 ? afc_pkg::CHUNK_Y_SIZE : afc_pkg::CHUNK_Z_SIZE) * 8;
      if (c < 0) c = -c;
      sq += longint'(c * c);
    end
    root_dist = int_sqrt(sq);
    limit = frustum_regs[afc_pkg::REG_LIMITS][31:0];
    far_off = longint'($signed(frustum_regs[afc_pkg::REG_LIMITS][62:32]));
    unpack3(frustum_regs[afc_pkg::REG_BOX_MIN], fmin);
    unpack3(frustum_regs[afc_pkg::REG_BOX_MAX], fmax);
    unpack3(frustum_regs[afc_pkg::REG_LOOK], look);
    r.tag_out = b.tag;
    r.distance = (root_dist > 64'(afc_pkg::DistMax)) ? afc_pkg::DistMax
                                                      : root_dist[afc_pkg::DistW-1:0];
    if (!b.initialized) begin
      r.verdict = afc_pkg::VERDICT_SKIPPED;
    end else if (root_dist > limit) begin
      r.verdict = afc_pkg::VERDICT_TOO_FAR;
    end else begin
      overlap = 1'b1;
      for (int i = 0; i < 3; i++) begin
        mx = (lo[i] > fmin[i]) ? lo[i] : fmin[i];
        mn = (hi[i] < fmax[i]) ? hi[i] : fmax[i];
        if (mx > mn) overlap = 1'b0;
      end
      culled = !overlap || (corner_min_dot(lo, hi, look) - far_off >= 0);
      for (int p = 0; p < 4; p++) begin
        unpack3(frustum_regs[p], n);
        if (corner_min_dot(lo, hi, n) >= 0) culled = 1'b1;
      end
      if (culled) r.verdict = afc_pkg::VERDICT_CULLED;
      else if (!b.mesh_ready) r.verdict = afc_pkg::VERDICT_MESH;
      else r.verdict = afc_pkg::VERDICT_VISIBLE;
    end
    return r;
  endfunction

  task automatic write_reg(afc_pkg::reg_idx_e idx, logic [afc_pkg::RegW-1:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    frustum_regs[idx] = val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Plain camera looking down +z with outward side normals of the given scale.
  task automatic load_camera(int s, int look_z, int far_z, logic [31:0] lim,
                             logic [afc_pkg::RegW-1:0] bmin,
                             logic [afc_pkg::RegW-1:0] bmax);
    write_reg(afc_pkg::REG_NORMAL_TOP,    pack3(0, s, -s));
    write_reg(afc_pkg::REG_NORMAL_BOTTOM, pack3(0, -s, -s));
    write_reg(afc_pkg::REG_NORMAL_LEFT,   pack3(-s, 0, -s));
    write_reg(afc_pkg::REG_NORMAL_RIGHT,  pack3(s, 0, -s));
    write_reg(afc_pkg::REG_LOOK,          pack3(0, 0, look_z));
    write_reg(afc_pkg::REG_BOX_MIN,       bmin);
    write_reg(afc_pkg::REG_BOX_MAX,       bmax);
    write_reg(afc_pkg::REG_LIMITS,        {31'(longint'(look_z) * far_z), lim});
  endtask

  // Registers change only once the pipeline has drained.
  task automatic select_setting(int set);
    if (set == cur_set) return;
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    wait (pending_culls.size() == 0);
    repeat (PipeDepth + 3) @(negedge clk_i);
    cur_set = set;
    case (set)
      1: load_camera(1000, 1, 64000, 32'd70000, pack3(-70000, -70000, -16),
                     pack3(70000, 70000, 70000));
      2: load_camera(3, 7, 30000, 32'd20000, pack3(-40000, -30000, 0),
                     pack3(40000, 30000, 40000));
      3: begin
        for (int i = 0; i < afc_pkg::NumRegs; i++) begin
          write_reg(afc_pkg::reg_idx_e'(i), '1);
        end
      end
      4: begin
        for (int i = 0; i < afc_pkg::NumRegs; i++) begin
          write_reg(afc_pkg::reg_idx_e'(i), afc_pkg::RegW'({$urandom, $urandom}));
        end
      end
      default: begin
        load_camera(77, 1, 40000, 32'hFFFF_FFFF, pack3(-1048576, -1048576, -1048576),
                    pack3(1048575, 1048575, 1048575));
        write_reg(afc_pkg::REG_LIMITS, {31'h3FFF_FFFF, 32'hFFFF_FFFF});
      end
    endcase
  endtask

  // Offers one beat, with random idle cycles first, and records its result.
  task automatic send_chunk(afc_pkg::in_beat_t b, bit typed, afc_pkg::out_beat_t typed_res);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_culls.push_back(typed ? typed_res : predict_cull(b));
  endtask

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= rcv_idle);
  end

  // Result checker: every beat must match the oldest pending expectation.
  always @(posedge clk_i) begin
    afc_pkg::out_beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_culls.size() == 0) begin
        $display("%0t: unexpected beat tag %h verdict %0d distance %0d", $time,
                 out_if.payload.tag_out, out_if.payload.verdict,
                 out_if.payload.distance);
        errors++;
      end else begin
        want = pending_culls.pop_front();
        if (out_if.payload.tag_out != want.tag_out
            || out_if.payload.verdict != want.verdict
            || out_if.payload.distance != want.distance) begin
          $display("%0t: expected tag %h verdict %0d distance %0d, got %h %0d %0d",
                   $time, want.tag_out, want.verdict, want.distance,
                   out_if.payload.tag_out, out_if.payload.verdict,
                   out_if.payload.distance);
          errors++;
        end
      end
    end
  end

  initial begin
    cull_row_t          rows [$];
    afc_pkg::in_beat_t  b;
    afc_pkg::out_beat_t t;
    int                 span;

    in_if.valid = 1'b0;
    in_if.payload = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    for (int i = 0; i < afc_pkg::NumRegs; i++) frustum_regs[i] = '0;

    // Directed rows; the first ones run on the cleared registers.
    rows = '{
      '{0, 16'h0000, -128, -128, -128, 1'b0, 1'b0, 1'b1, afc_pkg::VERDICT_SKIPPED, 0},
      '{0, 16'hFFFF, -128, -128, -128, 1'b1, 1'b1, 1'b1, afc_pkg::VERDICT_CULLED, 0},
      '{0, 16'h1234, -1048576, -1048576, -1048576, 1'b1, 1'b0, 1'b0,
        afc_pkg::VERDICT_SKIPPED, 0},
      '{0, 16'h5555, 1048575, 1048575, 1048575, 1'b1, 1'b1, 1'b0,
        afc_pkg::VERDICT_SKIPPED, 0},
      '{0, 16'hAAAA, 1048575, -1048576, 0, 1'b0, 1'b1, 1'b0, afc_pkg::VERDICT_SKIPPED, 0},
      '{0, 16'h0001, 0, 0, 0, 1'b1, 1'b0, 1'b0, afc_pkg::VERDICT_SKIPPED, 0},
      '{1, 16'h0100, -128, -128, 1600, 1'b1, 1'b0, 1'b0, afc_pkg::VERDICT_SKIPPED, 0},
      '{1, 16'h0101, -128, -128, 1600, 1'b1, 1'b1, 1'b0, afc_pkg::VERDICT_SKIPPED, 0},
      '{1, 16'h0102, -128, -128, 1600, 1'b0, 1'b1, 1'b0, afc_pkg::VERDICT_SKIPPED, 0},
      '{1, 16'h0103, -128, -128, 900000, 1'b1, 1'b1, 1'b0, afc_pkg::VERDICT_SKIPPED, 0},
      '{1, 16'h0104, -128, -128, -80000, 1'b1, 1'b1, 1'b0, afc_pkg::VERDICT_SKIPPED, 0},
      '{1, 16'h0105, 20000, -128, 10000, 1'b1, 1'b1, 1'b0, afc_pkg::VERDICT_SKIPPED, 0},
      '{1, 16'h0106, -30000, -128, 10000, 1'b1, 1'b1, 1'b0, afc_pkg::VERDICT_SKIPPED, 0},
      '{1, 16'h0107, -128, 20000, 10000, 1'b1, 1'b1, 1'b0, afc_pkg::VERDICT_SKIPPED, 0},
      '{1, 16'h0108, -128, -30000, 10000, 1'b1, 1'b1, 1'b0, afc_pkg::VERDICT_SKIPPED, 0},
      '{1, 16'h0109, -128, -128, 63000, 1'b1, 1'b0, 1'b0, afc_pkg::VERDICT_SKIPPED, 0},
      '{1, 16'h010A, -128, -128, 66000, 1'b1, 1'b0, 1'b0, afc_pkg::VERDICT_SKIPPED, 0}
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    snd_idle = 27;
    rcv_idle = 56;
    foreach (rows[i]) begin
      select_setting(rows[i].cfg_set);
      b.tag = rows[i].tag;
      b.rel_x = rows[i].x[20:0];
      b.rel_y = rows[i].y[20:0];
      b.rel_z = rows[i].z[20:0];
      b.initialized = rows[i].init;
      b.mesh_ready = rows[i].ready;
      t.tag_out = rows[i].tag;
      t.verdict = rows[i].verdict;
      t.distance = rows[i].exp_dist[afc_pkg::DistW-1:0];
      send_chunk(b, rows[i].typed, t);
    end

    // Random chunks over five register settings and three idle patterns.
    for (int k = 0; k < RandItems; k++) begin
      if (k == RandItems / 3) begin
        snd_idle = 56;
        rcv_idle = 27;
      end else if (k == 2 * RandItems / 3) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      if (k % ItemsPerSet == 0) begin
        select_setting(1 + k / ItemsPerSet);
      end
      if (k == 700) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
        wait (pending_culls.size() == 0);
      end
      span = ($urandom_range(9) == 0) ? 1048575 : 80000;
      b.tag = 16'($urandom);
      if (span == 1048575) begin
        b.rel_x = 21'($urandom);
        b.rel_y = 21'($urandom);
        b.rel_z = 21'($urandom);
      end else begin
        b.rel_x = 21'($urandom_range(2 * span) - span);
        b.rel_y = 21'($urandom_range(2 * span) - span);
        b.rel_z = 21'($urandom_range(span + 20000) - 20000);
      end
      b.initialized = ($urandom_range(9) != 0);
      b.mesh_ready = 1'($urandom);
      send_chunk(b, 1'b0, t);
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    wait (pending_culls.size() == 0);
    repeat (PipeDepth + 3) @(posedge clk_i);
    if (errors == 0) begin
      $display("aabb_frustum_cull test passed");
    end else begin
      $display("aabb_frustum_cull test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
